// File: rtl/core/postfix_expression_evaluator_top_macros.svh
// Assertion macros used by the checker file of the postfix evaluator.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Types, character codes and status codes shared by the postfix evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

  localparam int CHAR_W      = 8;
  localparam int RESULT_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_RIGHT,
    ST_RD_LEFT,
    ST_LOAD_LEFT,
    ST_ADD,
    ST_MUL,
    ST_ABS_LEFT,
    ST_ABS_RIGHT,
    ST_DIV,
    ST_DIV_SIGN,
    ST_PUSH,
    ST_RD_TOP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_DIV_ZERO  = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_t;

  // The first error of an expression is kept until the result goes out.
  function automatic status_t sticky(status_t cur, status_t code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

endpackage

// File: rtl/core/pfx_eval_ram.sv
// ----------------------------------------------------------------------------
// pfx_eval_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfx_eval_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Reverse Polish calculator over a stream of ASCII characters.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input transfer. A digit pushes its
// value onto a value stack held in a RAM; + - * / pop the right operand, then
// the left one, and push the wrapped VALUE_WIDTH-bit result, with division
// truncating toward zero. Other characters are ignored. On a transfer with
// tlast set, the character is processed first, then one result transfer goes
// out with the top of stack (zero if empty) and the first error seen since
// the previous result: underflow, divide by zero or overflow. The stack and
// the status are then cleared. All arithmetic runs through one shared adder
// under a small sequencer, and the input is not ready while it works. Digits
// and ignored characters need no sequencer steps; * runs one shift-add step
// per bit, and / runs sign removal, one restoring step per quotient bit and
// a sign fix, except / by zero, which skips them. An operator with fewer than
// two values held is not carried out. A transfer with tlast adds a top-of-stack
// read, plus any wait for the output register to be taken. The stack RAM has
// one write and one registered read port, so the two operands are fetched on
// separate cycles.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream: tdata[7:0] character; tlast marks the final character.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [pfx_eval_pkg::CHAR_W-1:0]        s_tdata,
  input  logic                                   s_tlast,
  // Result stream: tdata[31:0] value, [33:32] status, [39:34] zero.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [pfx_eval_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam int PtrW  = $clog2(STACK_DEPTH + 1);
  localparam int CntW  = $clog2(VALUE_WIDTH);
  localparam int SumW  = VALUE_WIDTH + 2;
  localparam int ExtW  = (VALUE_WIDTH > pfx_eval_pkg::RESULT_W) ?
                         VALUE_WIDTH : pfx_eval_pkg::RESULT_W;
  localparam int PadW  = pfx_eval_pkg::OUT_TDATA_W - pfx_eval_pkg::RESULT_W -
                         pfx_eval_pkg::STATUS_W;

  pfx_eval_pkg::state_t  state, state_next;
  pfx_eval_pkg::op_t     op;
  pfx_eval_pkg::status_t status;
  pfx_eval_pkg::status_t status_out;

  logic [PtrW-1:0]        sp;
  logic                   last_q;
  logic [VALUE_WIDTH-1:0] right_q;
  logic [VALUE_WIDTH-1:0] left_q;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] result_q;
  logic                   neg_q;
  logic [CntW-1:0]        count;
  logic [pfx_eval_pkg::RESULT_W-1:0] value_q;

  // Character decode.
  logic                   in_fire;
  logic                   is_digit;
  logic                   is_op;
  pfx_eval_pkg::op_t      char_op;
  logic [3:0]             digit;
  logic                   stack_full;
  logic                   two_held;
  logic                   out_free;
  logic                   count_end;
  logic [PtrW-1:0]        sp_dec1;
  logic [PtrW-1:0]        sp_dec2;

  // Shared adder.
  logic [VALUE_WIDTH:0]   add_a;
  logic [VALUE_WIDTH:0]   add_b;
  logic                   add_cin;
  logic [SumW-1:0]        sum;
  logic                   div_ge;

  // Stack RAM ports.
  logic                   ram_wr_en;
  logic [AddrW-1:0]       ram_wr_addr;
  logic [VALUE_WIDTH-1:0] ram_wr_data;
  logic [AddrW-1:0]       ram_rd_addr;
  logic [VALUE_WIDTH-1:0] ram_rd_data;
  logic [ExtW-1:0]        top_ext;

  assign in_fire    = s_tvalid && s_tready;
  assign is_digit   = (s_tdata >= pfx_eval_pkg::CHAR_ZERO) &&
                      (s_tdata <= pfx_eval_pkg::CHAR_NINE);
  assign is_op      = (s_tdata == pfx_eval_pkg::CHAR_PLUS)  ||
                      (s_tdata == pfx_eval_pkg::CHAR_MINUS) ||
                      (s_tdata == pfx_eval_pkg::CHAR_STAR)  ||
                      (s_tdata == pfx_eval_pkg::CHAR_SLASH);
  assign digit      = 4'(s_tdata - pfx_eval_pkg::CHAR_ZERO);
  assign stack_full = (sp >= PtrW'(STACK_DEPTH));
  assign two_held   = (sp >= PtrW'(2));
  assign out_free   = !m_tvalid || m_tready;
  assign count_end  = (count == CntW'(VALUE_WIDTH - 1));
  assign sp_dec1    = sp - PtrW'(1);
  assign sp_dec2    = sp - PtrW'(2);
  assign sum        = SumW'(add_a) + SumW'(add_b) + SumW'(add_cin);
  // Carry out of a subtract means the shifted remainder covers the divisor.
  assign div_ge     = sum[SumW-1];
  assign top_ext    = ExtW'(ram_rd_data);

  always_comb begin
    case (s_tdata)
      pfx_eval_pkg::CHAR_PLUS:  char_op = pfx_eval_pkg::OP_ADD;
      pfx_eval_pkg::CHAR_MINUS: char_op = pfx_eval_pkg::OP_SUB;
      pfx_eval_pkg::CHAR_STAR:  char_op = pfx_eval_pkg::OP_MUL;
      default:                  char_op = pfx_eval_pkg::OP_DIV;
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      pfx_eval_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_op && two_held) begin
            state_next = pfx_eval_pkg::ST_RD_RIGHT;
          end else if (s_tlast) begin
            state_next = pfx_eval_pkg::ST_RD_TOP;
          end
        end
      end
      pfx_eval_pkg::ST_RD_RIGHT: state_next = pfx_eval_pkg::ST_RD_LEFT;
      pfx_eval_pkg::ST_RD_LEFT:  state_next = pfx_eval_pkg::ST_LOAD_LEFT;
      pfx_eval_pkg::ST_LOAD_LEFT: begin
        case (op)
          pfx_eval_pkg::OP_ADD: state_next = pfx_eval_pkg::ST_ADD;
          pfx_eval_pkg::OP_SUB: state_next = pfx_eval_pkg::ST_ADD;
          pfx_eval_pkg::OP_MUL: state_next = pfx_eval_pkg::ST_MUL;
          default: begin
            state_next = (right_q == '0) ? pfx_eval_pkg::ST_PUSH
                                         : pfx_eval_pkg::ST_ABS_LEFT;
          end
        endcase
      end
      pfx_eval_pkg::ST_ADD: state_next = pfx_eval_pkg::ST_PUSH;
      pfx_eval_pkg::ST_MUL: begin
        if (count_end) begin
          state_next = pfx_eval_pkg::ST_PUSH;
        end
      end
      pfx_eval_pkg::ST_ABS_LEFT:  state_next = pfx_eval_pkg::ST_ABS_RIGHT;
      pfx_eval_pkg::ST_ABS_RIGHT: state_next = pfx_eval_pkg::ST_DIV;
      pfx_eval_pkg::ST_DIV: begin
        if (count_end) begin
          state_next = pfx_eval_pkg::ST_DIV_SIGN;
        end
      end
      pfx_eval_pkg::ST_DIV_SIGN: state_next = pfx_eval_pkg::ST_PUSH;
      pfx_eval_pkg::ST_PUSH: begin
        state_next = last_q ? pfx_eval_pkg::ST_RD_TOP : pfx_eval_pkg::ST_IDLE;
      end
      pfx_eval_pkg::ST_RD_TOP: state_next = pfx_eval_pkg::ST_EMIT;
      pfx_eval_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = pfx_eval_pkg::ST_IDLE;
        end
      end
      default: state_next = pfx_eval_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM ports and adder operands.
  always_comb begin
    s_tready    = (state == pfx_eval_pkg::ST_IDLE);
    ram_wr_en   = 1'b0;
    ram_wr_addr = sp[AddrW-1:0];
    ram_wr_data = VALUE_WIDTH'(digit);
    ram_rd_addr = (state == pfx_eval_pkg::ST_RD_LEFT) ? sp_dec2[AddrW-1:0]
                                                      : sp_dec1[AddrW-1:0];
    add_a       = '0;
    add_b       = '0;
    add_cin     = 1'b0;
    case (state)
      pfx_eval_pkg::ST_IDLE: begin
        ram_wr_en = in_fire && is_digit && !stack_full;
      end
      pfx_eval_pkg::ST_ADD: begin
        add_a = {1'b0, left_q};
        if (op == pfx_eval_pkg::OP_SUB) begin
          add_b   = {1'b0, ~right_q};
          add_cin = 1'b1;
        end else begin
          add_b   = {1'b0, right_q};
        end
      end
      pfx_eval_pkg::ST_MUL: begin
        add_a = {1'b0, acc};
        add_b = right_q[0] ? {1'b0, left_q} : '0;
      end
      pfx_eval_pkg::ST_ABS_LEFT: begin
        add_a   = {1'b0, left_q ^ {VALUE_WIDTH{left_q[VALUE_WIDTH-1]}}};
        add_cin = left_q[VALUE_WIDTH-1];
      end
      pfx_eval_pkg::ST_ABS_RIGHT: begin
        add_a   = {1'b0, right_q ^ {VALUE_WIDTH{right_q[VALUE_WIDTH-1]}}};
        add_cin = right_q[VALUE_WIDTH-1];
      end
      pfx_eval_pkg::ST_DIV: begin
        add_a   = {acc, left_q[VALUE_WIDTH-1]};
        add_b   = ~{1'b0, right_q};
        add_cin = 1'b1;
      end
      pfx_eval_pkg::ST_DIV_SIGN: begin
        add_a   = {1'b0, left_q ^ {VALUE_WIDTH{neg_q}}};
        add_cin = neg_q;
      end
      pfx_eval_pkg::ST_PUSH: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = sp_dec2[AddrW-1:0];
        ram_wr_data = result_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pfx_eval_pkg::ST_IDLE;
      sp       <= '0;
      status   <= pfx_eval_pkg::STAT_OK;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result may replace one that is being taken in the same cycle.
      if (state == pfx_eval_pkg::ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pfx_eval_pkg::ST_IDLE: begin
          if (in_fire && is_digit) begin
            if (stack_full) begin
              status <= pfx_eval_pkg::sticky(status, pfx_eval_pkg::STAT_OVERFLOW);
            end else begin
              sp <= sp + PtrW'(1);
            end
          end
          if (in_fire && is_op && !two_held) begin
            status <= pfx_eval_pkg::sticky(status, pfx_eval_pkg::STAT_UNDERFLOW);
          end
        end
        pfx_eval_pkg::ST_LOAD_LEFT: begin
          if (op == pfx_eval_pkg::OP_DIV && right_q == '0) begin
            status <= pfx_eval_pkg::sticky(status, pfx_eval_pkg::STAT_DIV_ZERO);
          end
        end
        pfx_eval_pkg::ST_PUSH: begin
          sp <= sp_dec1;
        end
        pfx_eval_pkg::ST_EMIT: begin
          if (out_free) begin
            sp     <= '0;
            status <= pfx_eval_pkg::STAT_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pfx_eval_pkg::ST_IDLE: begin
        if (in_fire) begin
          last_q <= s_tlast;
          op     <= char_op;
        end
      end
      pfx_eval_pkg::ST_RD_LEFT: begin
        right_q <= ram_rd_data;
      end
      pfx_eval_pkg::ST_LOAD_LEFT: begin
        left_q   <= ram_rd_data;
        acc      <= '0;
        count    <= '0;
        neg_q    <= ram_rd_data[VALUE_WIDTH-1] ^ right_q[VALUE_WIDTH-1];
        result_q <= '0;
      end
      pfx_eval_pkg::ST_ADD: begin
        result_q <= sum[VALUE_WIDTH-1:0];
      end
      pfx_eval_pkg::ST_MUL: begin
        // Shift-add: the multiplicand moves left, the multiplier right.
        acc      <= sum[VALUE_WIDTH-1:0];
        result_q <= sum[VALUE_WIDTH-1:0];
        left_q   <= {left_q[VALUE_WIDTH-2:0], 1'b0};
        right_q  <= {1'b0, right_q[VALUE_WIDTH-1:1]};
        count    <= count + CntW'(1);
      end
      pfx_eval_pkg::ST_ABS_LEFT: begin
        left_q <= sum[VALUE_WIDTH-1:0];
      end
      pfx_eval_pkg::ST_ABS_RIGHT: begin
        right_q <= sum[VALUE_WIDTH-1:0];
      end
      pfx_eval_pkg::ST_DIV: begin
        // Restoring division: left_q shifts the dividend out and the
        // quotient in, acc holds the partial remainder.
        acc    <= div_ge ? sum[VALUE_WIDTH-1:0]
                         : {acc[VALUE_WIDTH-2:0], left_q[VALUE_WIDTH-1]};
        left_q <= {left_q[VALUE_WIDTH-2:0], div_ge};
        count  <= count + CntW'(1);
      end
      pfx_eval_pkg::ST_DIV_SIGN: begin
        result_q <= sum[VALUE_WIDTH-1:0];
      end
      pfx_eval_pkg::ST_EMIT: begin
        if (out_free) begin
          if (sp == '0) begin
            value_q    <= '0;
            status_out <= pfx_eval_pkg::sticky(status, pfx_eval_pkg::STAT_UNDERFLOW);
          end else begin
            value_q    <= top_ext[pfx_eval_pkg::RESULT_W-1:0];
            status_out <= status;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {{PadW{1'b0}}, status_out, value_q};

  pfx_eval_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// File: rtl/core/pfx_eval_check.sv
// ----------------------------------------------------------------------------
// pfx_eval_check
// Port-level checks of the postfix evaluator, bound to its top level.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_top_macros.svh"

module pfx_eval_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [pfx_eval_pkg::CHAR_W-1:0]      s_tdata,
  input logic                                 s_tlast,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [pfx_eval_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int PadLo = pfx_eval_pkg::RESULT_W + pfx_eval_pkg::STATUS_W;

  logic digit_in;

  assign digit_in = (s_tdata >= pfx_eval_pkg::CHAR_ZERO) &&
                    (s_tdata <= pfx_eval_pkg::CHAR_NINE);

  // The final character always leads to a top-of-stack read.
  `PFX_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "ready after a final character")

  // A digit that does not end the expression leaves the input ready in the next cycle.
  `PFX_ASSERT_NEXT(a_digit_one_cycle, s_tvalid && s_tready && !s_tlast && digit_in, s_tready, "digit did not finish in one cycle")

  // A new result is loaded only from the emit step, when input is not taken.
  `PFX_ASSERT_NOW(a_result_from_emit, $rose(m_tvalid), $past(!s_tready), "result appeared while input was open")

  `PFX_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[pfx_eval_pkg::OUT_TDATA_W-1:PadLo] == '0, "nonzero padding in result")

  `PFX_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind postfix_expression_evaluator_top pfx_eval_check u_check (.*);
